// File: rtl/ezr_pkg.sv
// ----------------------------------------------------------------------------
// ezr_pkg: shared types and constants for the Euler ZYX rotation matrix
// Transaction payload structs, fixed-point format of the sine and cosine
// evaluation, series coefficients and pipeline depths.
// ----------------------------------------------------------------------------
package ezr_pkg;

  typedef struct packed {
    logic signed [15:0] angle_z;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_x;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } matrix_t;

  typedef struct packed {
    logic neg;   // sine takes a negative sign
    logic cneg;  // cosine takes a negative sign
    logic swap;  // angle was reflected about pi/4, sine and cosine trade places
  } fold_t;

  // Unsigned fixed point used inside the sine and cosine lanes.
  localparam int FX_FRAC = 44;
  localparam int FX_W    = 46;
  localparam int FX_HALF = 23;

  localparam logic [FX_W-1:0] FX_PI      = 46'h3243F6A8885A;
  localparam logic [FX_W-1:0] FX_PI_HALF = FX_PI >> 1;
  localparam logic [FX_W-1:0] FX_PI_QTR  = FX_PI >> 2;
  localparam logic [FX_W-1:0] FX_ONE     = 46'd1 << FX_FRAC;

  // Horner coefficients: SIN_COEF[k] = 1/(2k+1)!, COS_COEF[k] = 1/(2k)!.
  localparam logic [FX_W-1:0] SIN_COEF [0:8] = '{
    FX_ONE,
    FX_W'((64'd1 << FX_FRAC) / 64'd6),
    FX_W'((64'd1 << FX_FRAC) / 64'd120),
    FX_W'((64'd1 << FX_FRAC) / 64'd5040),
    FX_W'((64'd1 << FX_FRAC) / 64'd362880),
    FX_W'((64'd1 << FX_FRAC) / 64'd39916800),
    FX_W'((64'd1 << FX_FRAC) / 64'd6227020800),
    FX_W'((64'd1 << FX_FRAC) / 64'd1307674368000),
    FX_W'((64'd1 << FX_FRAC) / 64'd355687428096000)
  };

  localparam logic [FX_W-1:0] COS_COEF [0:8] = '{
    FX_ONE,
    FX_W'((64'd1 << FX_FRAC) / 64'd2),
    FX_W'((64'd1 << FX_FRAC) / 64'd24),
    FX_W'((64'd1 << FX_FRAC) / 64'd720),
    FX_W'((64'd1 << FX_FRAC) / 64'd40320),
    FX_W'((64'd1 << FX_FRAC) / 64'd3628800),
    FX_W'((64'd1 << FX_FRAC) / 64'd479001600),
    FX_W'((64'd1 << FX_FRAC) / 64'd87178291200),
    FX_W'((64'd1 << FX_FRAC) / 64'd20922789888000)
  };

  localparam int HORNER_STEPS = 8;
  localparam int MUL_LAT      = 2;
  localparam int STEP_LAT     = MUL_LAT + 1;
  localparam int T_DLY        = MUL_LAT + HORNER_STEPS * STEP_LAT;
  localparam int F_DLY        = T_DLY + MUL_LAT;
  localparam int LANE_LAT     = 1 + F_DLY + 1;
  localparam int MERGE_LAT    = 3;
  localparam int TOTAL_LAT    = LANE_LAT + MERGE_LAT;

endpackage

// File: rtl/ezr_mul.sv
// ----------------------------------------------------------------------------
// ezr_mul: two-stage unsigned fixed-point multiplier
// Four half-width partial products are registered, then summed and the
// product is truncated back to the lane format.
// ----------------------------------------------------------------------------
module ezr_mul (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ezr_pkg::FX_W-1:0]     a,
  input  logic [ezr_pkg::FX_W-1:0]     b,
  output logic [ezr_pkg::FX_W-1:0]     p
);

  localparam int H  = ezr_pkg::FX_HALF;
  localparam int W  = ezr_pkg::FX_W;
  localparam int PW = 2 * W;

  logic [2*H-1:0] pp_hh, pp_hl, pp_lh, pp_ll;
  logic [PW-1:0]  full;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= a[W-1:H] * b[W-1:H];
      pp_hl <= a[W-1:H] * b[H-1:0];
      pp_lh <= a[H-1:0] * b[W-1:H];
      pp_ll <= a[H-1:0] * b[H-1:0];
    end
  end

  assign full = (PW'(pp_hh) << (2 * H)) + ((PW'(pp_hl) + PW'(pp_lh)) << H) + PW'(pp_ll);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= full[ezr_pkg::FX_FRAC +: W];
    end
  end

endmodule

// File: rtl/ezr_lane.sv
// ----------------------------------------------------------------------------
// ezr_lane: sine and cosine of one angle
// Clamps and folds the angle into [0, pi/4], runs two Horner chains on t^2,
// and rounds both results to the output format with their signs restored.
// ----------------------------------------------------------------------------
module ezr_lane #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int OUT_FRAC_BITS   = 14
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic        [15:0]                angle,
  output logic signed [OUT_FRAC_BITS+1:0]   sin_q,
  output logic signed [OUT_FRAC_BITS+1:0]   cos_q
);

  localparam int W   = ezr_pkg::FX_W;
  localparam int F   = ezr_pkg::FX_FRAC;
  localparam int OW  = OUT_FRAC_BITS + 2;
  localparam int N   = ezr_pkg::HORNER_STEPS;
  localparam int ASH = F - ANGLE_FRAC_BITS;
  localparam int OSH = F - OUT_FRAC_BITS;
  localparam logic [W:0]  LIM_W = ({1'b0, ezr_pkg::FX_PI} + ((W+1)'(1) << (ASH - 1))) >> ASH;
  localparam logic [W:0]  RND   = (W+1)'(1) << (OSH - 1);

  // Angle clamp and fold. The limit is compared at full width, since for fine
  // angle formats it lies beyond anything the 16-bit field can carry.
  logic [16:0]       mag, mag_c;
  logic [W-1:0]      x, x1, t_next;
  ezr_pkg::fold_t    fold_next;
  logic [W-1:0]      t;
  ezr_pkg::fold_t    fold;

  always_comb begin
    fold_next.neg = angle[15];
    mag   = angle[15] ? (17'h10000 - {1'b0, angle}) : {1'b0, angle};
    mag_c = ((W+1)'(mag) > LIM_W) ? LIM_W[16:0] : mag;
    x     = W'(mag_c) << ASH;
    fold_next.cneg = 1'b0;
    x1 = x;
    if (x > ezr_pkg::FX_PI_HALF) begin
      x1 = (x >= ezr_pkg::FX_PI) ? '0 : ezr_pkg::FX_PI - x;
      fold_next.cneg = 1'b1;
    end
    fold_next.swap = 1'b0;
    t_next = x1;
    if (x1 > ezr_pkg::FX_PI_QTR) begin
      t_next = ezr_pkg::FX_PI_HALF - x1;
      fold_next.swap = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t    <= t_next;
      fold <= fold_next;
    end
  end

  // t squared.
  logic [W-1:0] t2_0;

  ezr_mul u_sq (.clk(clk), .en(en), .a(t), .b(t), .p(t2_0));

  // Horner chains, one step per generate iteration.
  logic [W-1:0] p_sin [1:N];
  logic [W-1:0] p_cos [1:N];
  logic [W-1:0] t2_d  [1:N];

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [W-1:0] t2_in, ps_in, pc_in, prod_s, prod_c, t2_m1, t2_m2;

    if (j == 0) begin : g_first
      assign t2_in = t2_0;
      assign ps_in = ezr_pkg::SIN_COEF[N];
      assign pc_in = ezr_pkg::COS_COEF[N];
    end else begin : g_rest
      assign t2_in = t2_d[j];
      assign ps_in = p_sin[j];
      assign pc_in = p_cos[j];
    end

    ezr_mul u_ms (.clk(clk), .en(en), .a(t2_in), .b(ps_in), .p(prod_s));
    ezr_mul u_mc (.clk(clk), .en(en), .a(t2_in), .b(pc_in), .p(prod_c));

    always_ff @(posedge clk) begin
      if (en) begin
        t2_m1      <= t2_in;
        t2_m2      <= t2_m1;
        t2_d[j+1]  <= t2_m2;
        p_sin[j+1] <= ezr_pkg::SIN_COEF[N-1-j] - prod_s;
        p_cos[j+1] <= ezr_pkg::COS_COEF[N-1-j] - prod_c;
      end
    end
  end

  // Delay lines for t and the fold flags.
  logic [W-1:0]   t_dly    [0:ezr_pkg::T_DLY-1];
  ezr_pkg::fold_t fold_dly [0:ezr_pkg::F_DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      t_dly[0]    <= t;
      fold_dly[0] <= fold;
      for (int i = 1; i < ezr_pkg::T_DLY; i++) begin
        t_dly[i] <= t_dly[i-1];
      end
      for (int i = 1; i < ezr_pkg::F_DLY; i++) begin
        fold_dly[i] <= fold_dly[i-1];
      end
    end
  end

  // Odd series needs one more multiply by t.
  logic [W-1:0] s_poly, c_d1, c_d2;

  ezr_mul u_st (.clk(clk), .en(en), .a(t_dly[ezr_pkg::T_DLY-1]), .b(p_sin[N]), .p(s_poly));

  always_ff @(posedge clk) begin
    if (en) begin
      c_d1 <= p_cos[N];
      c_d2 <= c_d1;
    end
  end

  // Round to nearest and restore signs.
  ezr_pkg::fold_t     fl;
  logic [W:0]         rs, rc;
  logic signed [OW-1:0] ms, mc, sv, cv;

  always_comb begin
    fl = fold_dly[ezr_pkg::F_DLY-1];
    rs = ({1'b0, s_poly} + RND) >> OSH;
    rc = ({1'b0, c_d2} + RND) >> OSH;
    ms = signed'(rs[OW-1:0]);
    mc = signed'(rc[OW-1:0]);
    sv = fl.swap ? mc : ms;
    cv = fl.swap ? ms : mc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= fl.neg  ? -sv : sv;
      cos_q <= fl.cneg ? -cv : cv;
    end
  end

endmodule

// File: rtl/ezr_merge.sv
// ----------------------------------------------------------------------------
// ezr_merge: combines the three sine and cosine pairs into the matrix
// Two rounds of rounded products, then saturated sums into the result
// register.
// ----------------------------------------------------------------------------
module ezr_merge #(
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [OUT_FRAC_BITS+1:0]  sa,
  input  logic signed [OUT_FRAC_BITS+1:0]  ca,
  input  logic signed [OUT_FRAC_BITS+1:0]  sb,
  input  logic signed [OUT_FRAC_BITS+1:0]  cb,
  input  logic signed [OUT_FRAC_BITS+1:0]  sc,
  input  logic signed [OUT_FRAC_BITS+1:0]  cc,
  output ezr_pkg::matrix_t                 matrix
);

  localparam int OW = OUT_FRAC_BITS + 2;
  localparam int PW = 2 * OW;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (OUT_FRAC_BITS - 1);
  localparam logic signed [OW:0]   ONE  = (OW+1)'(1) << OUT_FRAC_BITS;

  function automatic logic signed [OW-1:0] qmul(input logic signed [OW-1:0] a,
                                                 input logic signed [OW-1:0] b);
    logic signed [PW-1:0] p;
    p = a * b;
    p = p + HALF;
    return OW'(p >>> OUT_FRAC_BITS);
  endfunction

  function automatic logic signed [OW-1:0] qsat(input logic signed [OW:0] v);
    if (v > ONE) begin
      return OW'(ONE);
    end else if (v < -ONE) begin
      return OW'(-ONE);
    end
    return OW'(v);
  endfunction

  function automatic logic [15:0] fit(input logic signed [OW-1:0] v);
    return 16'(v);
  endfunction

  // First products.
  logic signed [OW-1:0] cacb, casb, sacc, sasc, sasb, cacc, casc, sacb, cbsc, cbcc;
  logic signed [OW-1:0] sc1, cc1, sb1;

  always_ff @(posedge clk) begin
    if (en) begin
      cacb <= qmul(ca, cb);
      casb <= qmul(ca, sb);
      sacc <= qmul(sa, cc);
      sasc <= qmul(sa, sc);
      sasb <= qmul(sa, sb);
      cacc <= qmul(ca, cc);
      casc <= qmul(ca, sc);
      sacb <= qmul(sa, cb);
      cbsc <= qmul(cb, sc);
      cbcc <= qmul(cb, cc);
      sc1  <= sc;
      cc1  <= cc;
      sb1  <= sb;
    end
  end

  // Second products of the triple terms.
  logic signed [OW-1:0] t01, t02, t11, t12;
  logic signed [OW-1:0] sacc2, sasc2, cacc2, casc2, cacb2, sacb2, cbsc2, cbcc2, sb2;

  always_ff @(posedge clk) begin
    if (en) begin
      t01   <= qmul(casb, sc1);
      t02   <= qmul(casb, cc1);
      t11   <= qmul(sasb, sc1);
      t12   <= qmul(sasb, cc1);
      sacc2 <= sacc;
      sasc2 <= sasc;
      cacc2 <= cacc;
      casc2 <= casc;
      cacb2 <= cacb;
      sacb2 <= sacb;
      cbsc2 <= cbsc;
      cbcc2 <= cbcc;
      sb2   <= sb1;
    end
  end

  // Saturated sums into the result register.
  always_ff @(posedge clk) begin
    if (en) begin
      matrix.m00 <= fit(cacb2);
      matrix.m01 <= fit(qsat((OW+1)'(t01) - (OW+1)'(sacc2)));
      matrix.m02 <= fit(qsat((OW+1)'(t02) + (OW+1)'(sasc2)));
      matrix.m10 <= fit(sacb2);
      matrix.m11 <= fit(qsat((OW+1)'(t11) + (OW+1)'(cacc2)));
      matrix.m12 <= fit(qsat((OW+1)'(t12) - (OW+1)'(casc2)));
      matrix.m20 <= fit(-sb2);
      matrix.m21 <= fit(cbsc2);
      matrix.m22 <= fit(cbcc2);
    end
  end

endmodule

// File: rtl/euler_zyx_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_zyx_rotation_matrix: rotation matrix Rz(a) * Ry(b) * Rx(c)
// Throughput: one transaction per cycle; the whole pipeline holds only
// while a finished matrix waits and matrix_ready is low.
// Reset clears the valid bits of the pipeline; data registers are not reset.
// ----------------------------------------------------------------------------
module euler_zyx_rotation_matrix #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int OUT_FRAC_BITS   = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             angles_valid,
  output logic             angles_ready,
  input  ezr_pkg::angles_t angles,
  output logic             matrix_valid,
  input  logic             matrix_ready,
  output ezr_pkg::matrix_t matrix
);

  localparam int OW = OUT_FRAC_BITS + 2;

  // The pipeline moves as one: every stage advances whenever the result
  // register is empty or its transaction is being taken this cycle. One
  // valid bit per stage follows the data.
  logic en;
  logic [ezr_pkg::TOTAL_LAT-1:0] vpipe;

  assign en           = !matrix_valid || matrix_ready;
  assign angles_ready = en;
  assign matrix_valid = vpipe[ezr_pkg::TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[ezr_pkg::TOTAL_LAT-2:0], angles_valid};
    end
  end

  // Three identical lanes, one for each angle, each giving its sine and
  // cosine in Q1.OUT_FRAC_BITS.
  logic        [15:0]   ang   [0:2];
  logic signed [OW-1:0] sin_l [0:2];
  logic signed [OW-1:0] cos_l [0:2];

  assign ang[0] = angles.angle_z;
  assign ang[1] = angles.angle_y;
  assign ang[2] = angles.angle_x;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    ezr_lane #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
      .OUT_FRAC_BITS  (OUT_FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .en   (en),
      .angle(ang[i]),
      .sin_q(sin_l[i]),
      .cos_q(cos_l[i])
    );
  end

  // The merge stage forms the nine entries and owns the result register.
  ezr_merge #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_merge (
    .clk   (clk),
    .en    (en),
    .sa    (sin_l[0]),
    .ca    (cos_l[0]),
    .sb    (sin_l[1]),
    .cb    (cos_l[1]),
    .sc    (sin_l[2]),
    .cc    (cos_l[2]),
    .matrix(matrix)
  );

endmodule
